// ===== hw/rtl/cftsf_pkg.sv =====
package cftsf_pkg;

    localparam int unsigned ID_W     = 11;
    localparam int unsigned DLC_W    = 4;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned HELD_W   = 11;
    localparam int unsigned MAX_DATA = 8;

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    // frame byte positions ahead of the data bytes
    localparam logic [3:0] STEP_SYNC0 = 4'd0;
    localparam logic [3:0] STEP_SYNC1 = 4'd1;
    localparam logic [3:0] STEP_ID_HI = 4'd2;
    localparam logic [3:0] STEP_ID_LO = 4'd3;
    localparam logic [3:0] STEP_DLC   = 4'd4;
    localparam logic [3:0] FIXED_LEN  = 4'd6;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WRITE = 3'b010,
        S_FIN   = 3'b100
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]         can_id;
        logic [DLC_W-1:0]        dlc;
        logic [7:0][BYTE_W-1:0]  data;
        logic [BYTE_W-1:0]       bus_status;
    } t_frame;

    function automatic logic [3:0] clamp_dlc(input logic [DLC_W-1:0] dlc);
        return (dlc > 4'(MAX_DATA)) ? 4'(MAX_DATA) : dlc;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [3:0] step, input t_frame f,
                                              input logic [3:0] ndata);
        logic [3:0] di;
        logic [7:0] b;
        di = step - STEP_DLC - 4'd1;
        case (step)
            STEP_SYNC0: b = SYNC_FIRST;
            STEP_SYNC1: b = SYNC_SECOND;
            STEP_ID_HI: b = {5'd0, f.can_id[10:8]};
            STEP_ID_LO: b = f.can_id[7:0];
            STEP_DLC:   b = {4'd0, f.dlc};
            default: begin
                if (di < ndata) begin
                    b = f.data[di[2:0]];
                end else begin
                    b = f.bus_status;
                end
            end
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/cftsf_if.sv =====
interface cftsf_in_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic [cftsf_pkg::ID_W-1:0]       can_id;
    logic [cftsf_pkg::DLC_W-1:0]      dlc;
    logic [cftsf_pkg::BYTE_W-1:0]     data0;
    logic [cftsf_pkg::BYTE_W-1:0]     data1;
    logic [cftsf_pkg::BYTE_W-1:0]     data2;
    logic [cftsf_pkg::BYTE_W-1:0]     data3;
    logic [cftsf_pkg::BYTE_W-1:0]     data4;
    logic [cftsf_pkg::BYTE_W-1:0]     data5;
    logic [cftsf_pkg::BYTE_W-1:0]     data6;
    logic [cftsf_pkg::BYTE_W-1:0]     data7;
    logic [cftsf_pkg::BYTE_W-1:0]     bus_status;

    modport source (
        output valid, kind, can_id, dlc, data0, data1, data2, data3,
               data4, data5, data6, data7, bus_status,
        input  ready
    );
    modport sink (
        input  valid, kind, can_id, dlc, data0, data1, data2, data3,
               data4, data5, data6, data7, bus_status,
        output ready
    );
endinterface

interface cftsf_out_if;
    logic                             valid;
    logic                             ready;
    logic [cftsf_pkg::BYTE_W-1:0]     out_byte;
    logic                             byte_valid;
    logic                             frame_accepted;
    logic                             overflow_seen;
    logic [cftsf_pkg::HELD_W-1:0]     bytes_held;

    modport source (
        output valid, out_byte, byte_valid, frame_accepted, overflow_seen, bytes_held,
        input  ready
    );
    modport sink (
        input  valid, out_byte, byte_valid, frame_accepted, overflow_seen, bytes_held,
        output ready
    );
endinterface

// ===== hw/rtl/cftsf_ram.sv =====
module cftsf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cftsf_adv.sv =====
module cftsf_adv #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic [$clog2(DEPTH)-1:0] i_idx,
    output logic [$clog2(DEPTH)-1:0] o_next
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    // wraps at the depth, so non power of two depths work too
    assign o_next = (i_idx == LAST) ? '0 : i_idx + AW'(1);

endmodule

// ===== hw/rtl/can_frame_to_serial_fifo_unit.sv =====
// CAN frame to serial byte FIFO.
// i_in carries two kinds of transfer: a received CAN frame (kind 0) or a drain
// request (kind 1) standing for one free serial transmit slot. o_out returns
// exactly one result per input transfer, in order.
// A frame is framed as 55, AA, id high, id low, dlc, min(dlc,8) data bytes and
// the status byte (6 to 14 bytes) and goes into the byte store only if all of
// it fits; otherwise it is dropped and overflow_seen stays set until reset.
// A drain pops one byte when the store is not empty.
// A stored frame goes through S_WRITE, where the single-port store takes one
// byte per cycle, and then S_FIN; a dropped frame or a drain goes straight to
// S_FIN. The result is registered on o_out as S_FIN is left;
// i_in.ready is low while an item is in work.
// One index-advance unit is shared by the write and read indices.
// Reset clears indices, fill count, overflow flag and the output valid flag;
// store contents are left as they are and only written bytes are ever read.
// While o_out is stalled the next item is still accepted and worked on; it then
// waits in its final cycle until the held result has been taken.
module can_frame_to_serial_fifo_unit #(
    parameter int unsigned BUFFER_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cftsf_in_if.sink    i_in,
    cftsf_out_if.source o_out
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CW:0] DEPTH_C = (CW + 1)'(BUFFER_DEPTH);

    cftsf_pkg::t_state r_state, n_state;
    cftsf_pkg::t_frame r_frame, n_frame;
    logic [3:0]        r_ndata, n_ndata;
    logic [3:0]        r_step, n_step;
    logic              r_acc, n_acc;
    logic              r_pop, n_pop;
    logic              r_ovf, n_ovf;
    logic [AW-1:0]     r_wr_idx, n_wr_idx;
    logic [AW-1:0]     r_rd_idx, n_rd_idx;
    logic [CW-1:0]     r_count, n_count;
    logic              r_out_valid, n_out_valid;

    logic [7:0]        r_out_byte;
    logic              r_byte_valid;
    logic              r_frame_acc;
    logic              r_out_ovf;
    logic [cftsf_pkg::HELD_W-1:0] r_out_held;

    logic              in_ready;
    logic              in_xfer;
    logic [3:0]        in_ndata;
    logic [3:0]        in_len;
    logic              in_fits;
    logic [3:0]        len;
    logic              fin_load;
    logic [AW-1:0]     adv_in;
    logic [AW-1:0]     adv_next;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    logic [CW+cftsf_pkg::HELD_W-1:0] held_ext;

    assign in_ready = (r_state == cftsf_pkg::S_IDLE) && i_rst_n;
    assign in_xfer  = i_in.valid && in_ready;
    assign in_ndata = cftsf_pkg::clamp_dlc(i_in.dlc);
    assign in_len   = cftsf_pkg::FIXED_LEN + in_ndata;
    assign in_fits  = ({1'b0, r_count} + (CW + 1)'(in_len)) <= DEPTH_C;
    assign len      = cftsf_pkg::FIXED_LEN + r_ndata;
    assign fin_load = (r_state == cftsf_pkg::S_FIN) && (!r_out_valid || o_out.ready);

    // one advance unit, write index while storing, read index otherwise
    assign adv_in = (r_state == cftsf_pkg::S_WRITE) ? r_wr_idx : r_rd_idx;

    cftsf_adv #(
        .DEPTH (BUFFER_DEPTH)
    ) u_adv (
        .i_idx  (adv_in),
        .o_next (adv_next)
    );

    assign ram_we    = (r_state == cftsf_pkg::S_WRITE);
    assign ram_addr  = ram_we ? r_wr_idx : r_rd_idx;
    assign ram_wdata = cftsf_pkg::frame_byte(r_step, r_frame, r_ndata);

    cftsf_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_frame     = r_frame;
        n_ndata     = r_ndata;
        n_step      = r_step;
        n_acc       = r_acc;
        n_pop       = r_pop;
        n_ovf       = r_ovf;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_out.ready;
        case (r_state)
            cftsf_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_frame.can_id     = i_in.can_id;
                    n_frame.dlc        = i_in.dlc;
                    n_frame.data[0]    = i_in.data0;
                    n_frame.data[1]    = i_in.data1;
                    n_frame.data[2]    = i_in.data2;
                    n_frame.data[3]    = i_in.data3;
                    n_frame.data[4]    = i_in.data4;
                    n_frame.data[5]    = i_in.data5;
                    n_frame.data[6]    = i_in.data6;
                    n_frame.data[7]    = i_in.data7;
                    n_frame.bus_status = i_in.bus_status;
                    n_ndata = in_ndata;
                    n_step  = '0;
                    n_acc   = !i_in.kind && in_fits;
                    n_pop   = i_in.kind && (r_count != '0);
                    if (!i_in.kind && !in_fits) begin
                        n_ovf = 1'b1;
                    end
                    n_state = (!i_in.kind && in_fits) ? cftsf_pkg::S_WRITE : cftsf_pkg::S_FIN;
                end
            end
            cftsf_pkg::S_WRITE: begin
                n_wr_idx = adv_next;
                n_step   = r_step + 4'd1;
                if (r_step == len - 4'd1) begin
                    n_state = cftsf_pkg::S_FIN;
                end
            end
            cftsf_pkg::S_FIN: begin
                if (fin_load) begin
                    n_out_valid = 1'b1;
                    n_count     = r_count + (r_acc ? CW'(len) : '0) - (r_pop ? CW'(1) : '0);
                    if (r_pop) begin
                        n_rd_idx = adv_next;
                    end
                    n_state = cftsf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cftsf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cftsf_pkg::S_IDLE;
            r_acc       <= 1'b0;
            r_pop       <= 1'b0;
            r_ovf       <= 1'b0;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_pop       <= n_pop;
            r_ovf       <= n_ovf;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
        end
    end

    // fill count masked to the width of the result field
    assign held_ext = (CW + cftsf_pkg::HELD_W)'(n_count);

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
        r_ndata <= n_ndata;
        if (fin_load) begin
            r_out_byte   <= r_pop ? ram_rdata : 8'd0;
            r_byte_valid <= r_pop;
            r_frame_acc  <= r_acc;
            r_out_ovf    <= r_ovf;
            r_out_held   <= held_ext[cftsf_pkg::HELD_W-1:0];
        end
    end

    assign i_in.ready           = in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out_byte;
    assign o_out.byte_valid     = r_byte_valid;
    assign o_out.frame_accepted = r_frame_acc;
    assign o_out.overflow_seen  = r_out_ovf;
    assign o_out.bytes_held     = r_out_held;

endmodule

// ===== hw/rtl/cftsf_chk.sv =====
module cftsf_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_byte_valid,
    input logic       i_frame_acc
);

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while an item is in work");

    a_kind_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_byte_valid && i_frame_acc))
        else $error("result flags both a popped byte and a stored frame");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_byte_valid) |-> (i_out_byte == 8'h00))
        else $error("byte field not zero without a popped byte");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte)))
        else $error("stalled result changed");

endmodule

bind can_frame_to_serial_fifo_unit cftsf_chk u_cftsf_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_byte_valid (o_out.byte_valid),
    .i_frame_acc  (o_out.frame_accepted)
);

// ===== sim/tb_top.sv =====
module tb_top;

    localparam int unsigned DEPTH       = 1024;
    localparam int unsigned ITEM_TARGET = 1800;
    localparam int unsigned IDLE_PCT    = 34;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic              kind;
        cftsf_pkg::t_frame frame;
    } t_fifo_req;

    typedef struct packed {
        logic [cftsf_pkg::BYTE_W-1:0] out_byte;
        logic                         byte_valid;
        logic                         frame_accepted;
        logic                         overflow_seen;
        logic [cftsf_pkg::HELD_W-1:0] bytes_held;
    } t_fifo_result;

    // data bytes of a row alternate between the pattern and its inverse
    typedef struct packed {
        logic                         kind;
        logic [cftsf_pkg::ID_W-1:0]   can_id;
        logic [cftsf_pkg::DLC_W-1:0]  dlc;
        logic [7:0]                   pattern;
        logic [7:0]                   status;
        logic                         typed;
        logic [7:0]                   w_byte;
        logic                         w_valid;
        logic                         w_acc;
        logic                         w_ovf;
        logic [cftsf_pkg::HELD_W-1:0] w_held;
    } t_dir_row;

    localparam int unsigned N_ROWS = 25;
    localparam t_dir_row DIRECTED_ROWS [N_ROWS] = '{
        // drain on an empty buffer straight after reset
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 11'd0},
        // shortest frame, all-zero fields
        '{KIND_FRAME, 11'h000, 4'h0, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 11'd6},
        // longest frame, dlc above eight, all ones
        '{KIND_FRAME, 11'h7ff, 4'hf, 8'hff, 8'hff, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 11'd20},
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b1, 8'h55, 1'b1, 1'b0, 1'b0, 11'd19},
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b1, 8'haa, 1'b1, 1'b0, 1'b0, 11'd18},
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 11'd17},
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 11'd16},
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 11'd15},
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 11'd14},
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b1, 8'h55, 1'b1, 1'b0, 1'b0, 11'd13},
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b1, 8'haa, 1'b1, 1'b0, 1'b0, 11'd12},
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b1, 8'h07, 1'b1, 1'b0, 1'b0, 11'd11},
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b1, 8'hff, 1'b1, 1'b0, 1'b0, 11'd10},
        // raw dlc byte kept even though only eight data bytes follow
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b1, 8'h0f, 1'b1, 1'b0, 1'b0, 11'd9},
        '{KIND_FRAME, 11'h555, 4'h8, 8'ha5, 8'h3c, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 11'd0},
        '{KIND_FRAME, 11'h2aa, 4'h9, 8'h5a, 8'hc3, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 11'd0},
        '{KIND_FRAME, 11'h001, 4'h1, 8'h80, 8'h01, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 11'd0},
        '{KIND_FRAME, 11'h400, 4'h7, 8'h01, 8'h80, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 11'd0},
        '{KIND_FRAME, 11'h0ff, 4'h4, 8'h33, 8'h7e, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 11'd0},
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 11'd0},
        '{KIND_DRAIN, 11'h7ff, 4'hf, 8'hff, 8'hff, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 11'd0},
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 11'd0},
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 11'd0},
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 11'd0},
        '{KIND_DRAIN, 11'h000, 4'h0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 11'd0}
    };

    logic i_clk;
    logic i_rst_n;
    logic steady;

    cftsf_in_if  in_ch ();
    cftsf_out_if out_ch ();

    can_frame_to_serial_fifo_unit #(
        .BUFFER_DEPTH(DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // predictor state
    logic [7:0]   byte_ring [DEPTH];
    int unsigned  wr_ptr;
    int unsigned  rd_ptr;
    int unsigned  fill_level;
    logic         ovf_sticky;

    t_fifo_result due_results [$];
    int unsigned  items_sent;
    int unsigned  results_seen;
    int unsigned  mismatches;
    int unsigned  frames_stored;
    int unsigned  frames_dropped;
    int unsigned  bytes_drained;
    int unsigned  empty_drains;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", due_results.size());
        $display("** can_frame_to_serial_fifo_unit: FAILED **");
        $finish;
    end

    function automatic t_fifo_result frame_fifo_step(input t_fifo_req req);
        t_fifo_result res;
        logic [7:0]   fbytes [14];
        int unsigned  ndata;
        int unsigned  flen;
        res = '0;
        if (req.kind == KIND_DRAIN) begin
            if (fill_level != 0) begin
                res.out_byte   = byte_ring[rd_ptr];
                res.byte_valid = 1'b1;
                rd_ptr         = (rd_ptr == DEPTH - 1) ? 0 : rd_ptr + 1;
                fill_level--;
                bytes_drained++;
            end else begin
                empty_drains++;
            end
        end else begin
            ndata     = (req.frame.dlc > cftsf_pkg::MAX_DATA) ? cftsf_pkg::MAX_DATA
                                                              : req.frame.dlc;
            fbytes[0] = cftsf_pkg::SYNC_FIRST;
            fbytes[1] = cftsf_pkg::SYNC_SECOND;
            fbytes[2] = {5'd0, req.frame.can_id[10:8]};
            fbytes[3] = req.frame.can_id[7:0];
            fbytes[4] = {4'd0, req.frame.dlc};
            for (int i = 0; i < ndata; i++) begin
                fbytes[5 + i] = req.frame.data[i];
            end
            fbytes[5 + ndata] = req.frame.bus_status;
            flen = ndata + 6;
            if (fill_level + flen <= DEPTH) begin
                for (int i = 0; i < flen; i++) begin
                    byte_ring[wr_ptr] = fbytes[i];
                    wr_ptr = (wr_ptr == DEPTH - 1) ? 0 : wr_ptr + 1;
                end
                fill_level += flen;
                res.frame_accepted = 1'b1;
                frames_stored++;
            end else begin
                ovf_sticky = 1'b1;
                frames_dropped++;
            end
        end
        res.overflow_seen = ovf_sticky;
        res.bytes_held    = fill_level[cftsf_pkg::HELD_W-1:0];
        return res;
    endfunction

    function automatic t_fifo_req random_item(input logic kind);
        t_fifo_req req;
        req.kind         = kind;
        req.frame.can_id = cftsf_pkg::ID_W'($urandom_range(0, 2047));
        // mostly legal lengths, a quarter above eight
        if ($urandom_range(0, 3) == 0) begin
            req.frame.dlc = cftsf_pkg::DLC_W'($urandom_range(9, 15));
        end else begin
            req.frame.dlc = cftsf_pkg::DLC_W'($urandom_range(0, 8));
        end
        for (int i = 0; i < 8; i++) begin
            req.frame.data[i] = 8'($urandom);
        end
        req.frame.bus_status = 8'($urandom);
        return req;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [10:0] got,
                               input logic [10:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      results_seen, name, got, want));
        end
    endtask

    // offer one item, wait for its transfer, then predict its result
    task automatic send_item(input t_fifo_req req, input logic use_typed,
                             input t_fifo_result typed_res);
        t_fifo_result res;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= req.kind;
        in_ch.can_id     <= req.frame.can_id;
        in_ch.dlc        <= req.frame.dlc;
        in_ch.data0      <= req.frame.data[0];
        in_ch.data1      <= req.frame.data[1];
        in_ch.data2      <= req.frame.data[2];
        in_ch.data3      <= req.frame.data[3];
        in_ch.data4      <= req.frame.data[4];
        in_ch.data5      <= req.frame.data[5];
        in_ch.data6      <= req.frame.data[6];
        in_ch.data7      <= req.frame.data[7];
        in_ch.bus_status <= req.frame.bus_status;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
        res = frame_fifo_step(req);
        due_results.push_back(use_typed ? typed_res : res);
    endtask

    task automatic send_random(input int unsigned frame_pct);
        t_fifo_req   req;
        int unsigned room;
        if ($urandom_range(0, 99) < frame_pct) begin
            req  = random_item(KIND_FRAME);
            room = DEPTH - fill_level;
            // now and then pick a length that fills the buffer exactly
            if (room >= 6 && room <= 14 && $urandom_range(0, 1) == 0) begin
                req.frame.dlc = cftsf_pkg::DLC_W'(room - 6);
            end
        end else begin
            req = random_item(KIND_DRAIN);
        end
        send_item(req, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_fifo_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("result transfer with nothing outstanding");
            end else begin
                want = due_results.pop_front();
                check_field("out_byte", 11'(out_ch.out_byte), 11'(want.out_byte));
                check_field("byte_valid", 11'(out_ch.byte_valid), 11'(want.byte_valid));
                check_field("frame_accepted", 11'(out_ch.frame_accepted),
                            11'(want.frame_accepted));
                check_field("overflow_seen", 11'(out_ch.overflow_seen),
                            11'(want.overflow_seen));
                check_field("bytes_held", out_ch.bytes_held, want.bytes_held);
            end
            results_seen++;
        end
    end

    initial begin
        t_fifo_req    req;
        t_fifo_result typed_res;
        t_dir_row     row;
        int unsigned  burst;
        int unsigned  frame_pct;

        i_rst_n          = 1'b0;
        steady           = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_FRAME;
        in_ch.can_id     = '0;
        in_ch.dlc        = '0;
        in_ch.data0      = '0;
        in_ch.data1      = '0;
        in_ch.data2      = '0;
        in_ch.data3      = '0;
        in_ch.data4      = '0;
        in_ch.data5      = '0;
        in_ch.data6      = '0;
        in_ch.data7      = '0;
        in_ch.bus_status = '0;
        out_ch.ready     = 1'b0;
        wr_ptr           = 0;
        rd_ptr           = 0;
        fill_level       = 0;
        ovf_sticky       = 1'b0;
        items_sent       = 0;
        results_seen     = 0;
        mismatches       = 0;
        frames_stored    = 0;
        frames_dropped   = 0;
        bytes_drained    = 0;
        empty_drains     = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            row          = DIRECTED_ROWS[r];
            req.kind     = row.kind;
            req.frame.can_id = row.can_id;
            req.frame.dlc    = row.dlc;
            for (int i = 0; i < 8; i++) begin
                req.frame.data[i] = i[0] ? ~row.pattern : row.pattern;
            end
            req.frame.bus_status     = row.status;
            typed_res.out_byte       = row.w_byte;
            typed_res.byte_valid     = row.w_valid;
            typed_res.frame_accepted = row.w_acc;
            typed_res.overflow_seen  = row.w_ovf;
            typed_res.bytes_held     = row.w_held;
            send_item(req, row.typed, typed_res);
        end

        // fill burst: runs the buffer into overflow
        repeat (140) send_random(90);

        // drain down to empty, the first stretch with no idling on either side
        steady = 1'b1;
        burst  = 0;
        while (fill_level != 0) begin
            if (burst == 300) begin
                steady = 1'b0;
            end
            send_random(1);
            burst++;
        end
        steady = 1'b0;
        repeat (4) send_random(0);

        // mixed traffic in blocks of varying frame share
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 3))
                0: frame_pct = 5;
                1: frame_pct = 8;
                2: frame_pct = 15;
                default: frame_pct = 40;
            endcase
            repeat (100) send_random(frame_pct);
        end

        in_ch.valid <= 1'b0;
        while (due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("covered %0d items: %0d frames stored, %0d frames dropped",
                 items_sent, frames_stored, frames_dropped);
        $display("%0d bytes drained, %0d drains on an empty buffer, %0d mismatches",
                 bytes_drained, empty_drains, mismatches);
        if (mismatches == 0) begin
            $display("** can_frame_to_serial_fifo_unit: PASSED **");
        end else begin
            $display("** can_frame_to_serial_fifo_unit: FAILED **");
        end
        $finish;
    end

endmodule
